// ===== hdl/nfa_pkg.sv =====
package nfa_pkg;

  // field widths
  localparam int ID_W      = 10;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // bitmap word layout
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ID_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_MAX = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_BEGIN,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

// ===== hdl/next_fit_id_allocator_unit.sv =====
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------
// command   | start, busy            | func, id
// result    | done (one-cycle pulse) | status, allocated_id
// config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// sequence: free or a specific-id alloc goes through lookup and update before
//   the done beat (lookup alone when the requested id is out of range); an
//   any-id alloc scans the bitmap one 32-bit word per cycle through the RAM
//   read port, two passes at most
// reset: synchronous; the bitmap reads as clear through per-word valid bits,
//   so no clearing pass is needed and the block is ready right after reset
// stalls: busy holds off commands; results cannot be held off by the receiver
module next_fit_id_allocator_unit #(
  parameter int ID_COUNT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [nfa_pkg::ID_W-1:0]        id,
  output logic                            done,
  output logic [nfa_pkg::STATUS_W-1:0]    status,
  output logic [nfa_pkg::ID_W-1:0]        allocated_id,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nfa_pkg::ID_W-1:0]        cfg_data
);

  import nfa_pkg::*;

  // ids that fit both the id field and the bitmap
  localparam int ID_LIMIT = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int WORDS    = (ID_LIMIT + WORD_W - 1) / WORD_W;
  localparam int WAW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [ID_W-1:0] ID_TOP = ID_W'(ID_LIMIT - 1);

  state_t state, state_next;

  // configuration and allocator state
  logic [ID_W-1:0] id_min, id_max, next_id;
  logic [WORDS-1:0] word_vld;

  // latched command
  logic            op_func;
  logic [ID_W-1:0] op_id;

  // scan control
  logic            pass2;
  logic [ID_W-1:0] lo_q, hi_q;
  logic [WAW-1:0]  rd_word, chk_word;
  logic            issue_done, chk_pend;
  logic [WAW-1:0]  hit_word;
  logic [BIT_W-1:0] hit_bit_q;
  logic [WORD_W-1:0] hit_data;

  // ram ports
  logic              ram_we;
  logic [WAW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic              rd_vld_q;

  // combinational datapath
  logic [WORD_W-1:0] data_eff, mask_lo, mask_hi, free_bits, op_bitsel;
  logic [BIT_W-1:0]  hit_bit;
  logic              op_in_map, op_out_range, pass_empty;
  logic [ID_W-1:0]   lo_new, hi_new, start_id;
  logic [ID_W:0]     hit_id_inc;
  logic [ID_W-1:0]   hit_id;
  logic              resp_fire;
  logic [STATUS_W-1:0] resp_status;
  logic [ID_W-1:0]   resp_id;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  nfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // a word never written reads as all clear
  assign data_eff  = ram_rdata & {WORD_W{rd_vld_q}};
  assign op_bitsel = WORD_W'(1) << op_id[BIT_W-1:0];
  assign op_in_map = ({1'b0, op_id} < (ID_W + 1)'(ID_LIMIT));
  assign op_out_range = (op_id < id_min) || (op_id > id_max) || !op_in_map;

  // search bounds for the pass about to start
  assign start_id   = (next_id < id_min) ? id_min : next_id;
  assign lo_new     = pass2 ? id_min : start_id;
  assign hi_new     = (id_max > ID_TOP) ? ID_TOP : id_max;
  assign pass_empty = (lo_new > hi_new);

  // free bits of the checked word inside [lo, hi]
  assign mask_lo = (chk_word == WAW'(lo_q >> BIT_W)) ?
                   ({WORD_W{1'b1}} << lo_q[BIT_W-1:0]) : {WORD_W{1'b1}};
  assign mask_hi = (chk_word == WAW'(hi_q >> BIT_W)) ?
                   ({WORD_W{1'b1}} >> (~hi_q[BIT_W-1:0])) : {WORD_W{1'b1}};
  assign free_bits = ~data_eff & mask_lo & mask_hi;

  // lowest free bit
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  assign hit_id     = ID_W'({hit_word, hit_bit_q});
  assign hit_id_inc = {1'b0, hit_id} + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = ((func == FUNC_FREE) || (id != '0)) ? S_LOOKUP : S_BEGIN;
        end
      end
      S_LOOKUP: begin
        if (op_func == FUNC_FREE) begin
          state_next = op_in_map ? S_UPDATE : S_IDLE;
        end else begin
          state_next = op_out_range ? S_IDLE : S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_IDLE;
      S_BEGIN: begin
        if (!pass_empty) begin
          state_next = S_SCAN;
        end else if (pass2) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (chk_pend && (free_bits != '0)) begin
          state_next = S_COMMIT;
        end else if (issue_done && !chk_pend) begin
          state_next = pass2 ? S_IDLE : S_BEGIN;
        end
      end
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ram controls and result
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = WAW'(op_id >> BIT_W);
    ram_wdata   = data_eff;
    ram_raddr   = rd_word;
    resp_fire   = 1'b0;
    resp_status = ST_OK;
    resp_id     = '0;
    case (state)
      S_LOOKUP: begin
        ram_raddr = WAW'(op_id >> BIT_W);
        if ((op_func == FUNC_FREE) && !op_in_map) begin
          resp_fire = 1'b1;
        end else if ((op_func == FUNC_ALLOC) && op_out_range) begin
          resp_fire   = 1'b1;
          resp_status = ST_INVALID;
        end
      end
      S_UPDATE: begin
        resp_fire = 1'b1;
        if (op_func == FUNC_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = data_eff & ~op_bitsel;
        end else if ((data_eff & op_bitsel) != '0) begin
          resp_status = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = data_eff | op_bitsel;
          resp_id   = op_id;
        end
      end
      S_BEGIN: begin
        if (pass_empty && pass2) begin
          resp_fire   = 1'b1;
          resp_status = ST_FULL;
        end
      end
      S_SCAN: begin
        if (!(chk_pend && (free_bits != '0)) && issue_done && !chk_pend && pass2) begin
          resp_fire   = 1'b1;
          resp_status = ST_FULL;
        end
      end
      S_COMMIT: begin
        ram_we    = 1'b1;
        ram_waddr = hit_word;
        ram_wdata = hit_data | (WORD_W'(1) << hit_bit_q);
        resp_fire = 1'b1;
        resp_id   = hit_id;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      id_min   <= '0;
      id_max   <= ID_W'(1023);
      next_id  <= '0;
      word_vld <= '0;
      done     <= 1'b0;
      chk_pend <= 1'b0;
    end else begin
      state <= state_next;
      done  <= resp_fire;

      // configuration beat
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ID_MIN) begin
          id_min <= cfg_data;
        end else if (cfg_index == REG_ID_MAX) begin
          id_max <= cfg_data;
        end
      end

      if (ram_we) begin
        word_vld[ram_waddr] <= 1'b1;
      end

      // advance the next-fit pointer on an any-id grant
      if (state == S_COMMIT) begin
        next_id <= (hit_id_inc > {1'b0, id_max}) ? id_min : hit_id_inc[ID_W-1:0];
      end

      chk_pend <= (state == S_SCAN) && !issue_done;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    rd_vld_q <= word_vld[ram_raddr];
    chk_word <= rd_word;

    if (resp_fire) begin
      status       <= resp_status;
      allocated_id <= resp_id;
    end

    case (state)
      S_IDLE: begin
        op_func <= func;
        op_id   <= id;
        pass2   <= 1'b0;
      end
      S_BEGIN: begin
        lo_q       <= lo_new;
        hi_q       <= hi_new;
        rd_word    <= WAW'(lo_new >> BIT_W);
        issue_done <= 1'b0;
        if (pass_empty) begin
          pass2 <= 1'b1;
        end
      end
      S_SCAN: begin
        if (!issue_done) begin
          rd_word <= rd_word + 1'b1;
          if (rd_word == WAW'(hi_q >> BIT_W)) begin
            issue_done <= 1'b1;
          end
        end
        if (chk_pend && (free_bits != '0)) begin
          hit_word  <= chk_word;
          hit_bit_q <= hit_bit;
          hit_data  <= data_eff;
        end else if (issue_done && !chk_pend) begin
          pass2 <= 1'b1;
        end
      end
      default: begin
        pass2 <= pass2;
      end
    endcase
  end

endmodule

// ===== hdl/nfa_ram.sv =====
module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/nfa_checker.sv =====
module nfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [nfa_pkg::STATUS_W-1:0]  status,
  input logic [nfa_pkg::ID_W-1:0]      allocated_id
);

  import nfa_pkg::*;

  // a result only comes out once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // an accepted command keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // every command that finishes delivers a result
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("command finished without a result beat");

  // failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (allocated_id == '0))
    else $error("failed request carries an id");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_OK) || (status == ST_INVALID) || (status == ST_FULL)))
    else $error("undefined status code");

endmodule

bind next_fit_id_allocator_unit nfa_checker u_nfa_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .allocated_id(allocated_id)
);

// ===== tb/next_fit_id_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module next_fit_id_allocator_unit_tb;
  import nfa_pkg::*;

  localparam int N_IDS = 1024;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 100;

  // one expected grant
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
  } grant_t;

  // next-fit predictor plus the queue of grants still owed by the block
  class id_pool_scoreboard;
    bit              used [N_IDS];
    logic [ID_W-1:0] next_ptr;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    grant_t          grant_q[$];
    int errors;
    int n_checked;
    int n_ok;
    int n_full;
    int n_invalid;
    int n_free;

    function new();
      lo       = '0;
      hi       = ID_W'(N_IDS - 1);
      next_ptr = '0;
    endfunction

    // register writes leave the bitmap and the search pointer alone
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] value);
      if (idx == REG_ID_MIN) lo = value;
      else hi = value;
    endfunction

    // lowest clear bit in [from, upto]
    function bit lowest_free(int from, int upto, output int found);
      int k;
      found = 0;
      for (k = from; k <= upto; k++) begin
        if (!used[k]) begin
          found = k;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic fn, logic [ID_W-1:0] req);
      grant_t g;
      int     start_at;
      int     found;
      bit     ok;
      g.status = ST_OK;
      g.id     = '0;
      if (fn == FUNC_FREE) begin
        used[req] = 1'b0;
        n_free++;
      end else if (req != '0) begin
        // exact id request
        if (req < lo || req > hi) g.status = ST_INVALID;
        else if (used[req]) g.status = ST_FULL;
        else begin
          used[req] = 1'b1;
          g.id = req;
        end
      end else begin
        // any id: search from the pointer, then retry over the whole range
        start_at = (next_ptr < lo) ? int'(lo) : int'(next_ptr);
        ok = lowest_free(start_at, int'(hi), found);
        if (!ok) ok = lowest_free(int'(lo), int'(hi), found);
        if (!ok) g.status = ST_FULL;
        else begin
          used[found] = 1'b1;
          g.id = ID_W'(found);
          next_ptr = (found + 1 > int'(hi)) ? lo : ID_W'(found + 1);
        end
      end
      if (fn != FUNC_FREE) begin
        if (g.status == ST_OK) n_ok++;
        else if (g.status == ST_FULL) n_full++;
        else n_invalid++;
      end
      grant_q.push_back(g);
    endfunction

    function void check_grant(logic [STATUS_W-1:0] st, logic [ID_W-1:0] gid);
      grant_t g;
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: status %0d id %0d", $realtime, st, gid);
        return;
      end
      g = grant_q.pop_front();
      n_checked++;
      if (st !== g.status || gid !== g.id) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %0d: expected status %0d id %0d, got status %0d id %0d",
                   $realtime, n_checked, g.status, g.id, st, gid);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 func = FUNC_ALLOC;
  logic [ID_W-1:0]      id = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      allocated_id;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ID_MIN;
  logic [ID_W-1:0]      cfg_data = '0;

  id_pool_scoreboard sb = new();
  int n_items;
  int n_writes;
  int n_phases;

  next_fit_id_allocator_unit #(.ID_COUNT(N_IDS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .id           (id),
    .done         (done),
    .status       (status),
    .allocated_id (allocated_id),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_grant(status, allocated_id);
  end

  // present one command and hold it until the block takes the beat
  task automatic issue(logic fn, logic [ID_W-1:0] req);
    start <= 1'b1;
    func  <= fn;
    id    <= req;
    do @(posedge clk); while (busy);
    sb.note_request(fn, req);
    n_items++;
  endtask

  // gap between bursts
  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait until every grant has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.grant_q.size() != 0 || busy);
  endtask

  // one config beat; the caller drops valid after its last beat
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
    n_writes++;
  endtask

  task automatic set_range(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
    drain();
    write_reg(REG_ID_MIN, lo);
    write_reg(REG_ID_MAX, hi);
    cfg_valid <= 1'b0;
  endtask

  // random range: mostly small windows so the pool fills up, plus inverted windows and the extremes
  task automatic pick_range(output logic [ID_W-1:0] lo, output logic [ID_W-1:0] hi);
    int base;
    case ($urandom_range(0, 9))
      0: begin lo = '0; hi = '1; end
      1: begin hi = ID_W'($urandom_range(0, 1000)); lo = hi + ID_W'($urandom_range(1, 20)); end
      2: begin lo = ID_W'($urandom_range(0, N_IDS - 1)); hi = lo; end
      3: begin lo = '1; hi = '1; end
      4: begin lo = '0; hi = ID_W'($urandom_range(0, 8)); end
      5: begin hi = '1; lo = ID_W'($urandom_range(N_IDS - 40, N_IDS - 1)); end
      default: begin
        base = $urandom_range(0, N_IDS - 1);
        lo = ID_W'(base);
        hi = ID_W'((base + $urandom_range(0, 48) > N_IDS - 1) ? N_IDS - 1
                   : base + $urandom_range(0, 48));
      end
    endcase
  endtask

  // random command, biased toward the configured window
  task automatic pick_item(output logic fn, output logic [ID_W-1:0] req);
    int r;
    logic [ID_W-1:0] near;
    r = $urandom_range(0, 99);
    near = (sb.lo <= sb.hi) ? ID_W'($urandom_range(sb.lo, sb.hi))
                            : ID_W'($urandom_range(0, N_IDS - 1));
    if (r < 40) begin
      fn = FUNC_ALLOC; req = '0;
    end else if (r < 60) begin
      fn = FUNC_ALLOC; req = near;
    end else if (r < 68) begin
      fn = FUNC_ALLOC; req = ID_W'($urandom_range(0, N_IDS - 1));
    end else if (r < 90) begin
      fn = FUNC_FREE; req = near;
    end else begin
      fn = FUNC_FREE; req = ID_W'($urandom_range(0, N_IDS - 1));
    end
  endtask

  // stimulus
  initial begin
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic            fn;
    logic [ID_W-1:0] req;
    int phase_len;
    int burst_left;
    bit calm;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset window: pointer walk, top id, double grant, double release
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, '1);
    issue(FUNC_ALLOC, '1);
    issue(FUNC_FREE, '1);
    issue(FUNC_FREE, '1);
    issue(FUNC_FREE, '0);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, 10'h155);
    issue(FUNC_FREE, 10'h2aa);

    // pointer below the window, requests outside it, window runs full
    set_range(10'd5, 10'd7);
    issue(FUNC_ALLOC, 10'd3);
    issue(FUNC_ALLOC, 10'd8);
    repeat (4) issue(FUNC_ALLOC, '0);

    // inverted window
    set_range(10'd9, 10'd4);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, 10'd5);

    // pointer above the window after the top is lowered
    set_range(10'd10, 10'd20);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, '0);
    set_range(10'd10, 10'd11);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_FREE, 10'd10);
    issue(FUNC_ALLOC, '0);

    // single-id windows at both ends
    set_range('1, '1);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, '1);
    set_range('0, '0);
    issue(FUNC_ALLOC, '0);

    // random phases, each with its own window
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      pick_range(lo, hi);
      set_range(lo, hi);
      n_phases++;
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 110);
      burst_left = $urandom_range(1, 10);
      repeat (phase_len) begin
        pick_item(fn, req);
        issue(fn, req);
        burst_left--;
        if (burst_left == 0) begin
          pause(calm ? 0 : $urandom_range(0, 12));
          burst_left = $urandom_range(1, 10);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d random commands over %0d windows, %0d register writes",
             n_items, n_phases, n_writes);
    $display("grants %0d, no-free %0d, out-of-range %0d, releases %0d, bad results %0d",
             sb.n_ok, sb.n_full, sb.n_invalid, sb.n_free, sb.errors);
    if (sb.errors == 0 && sb.grant_q.size() == 0) begin
      $display("next_fit_id_allocator_unit: match");
    end else begin
      $display("next_fit_id_allocator_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.grant_q.size());
    $display("next_fit_id_allocator_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nfa_pkg.sv
hdl/nfa_ram.sv
hdl/next_fit_id_allocator_unit.sv
hdl/nfa_checker.sv
tb/next_fit_id_allocator_unit_tb.sv
